@@ sv/tqsf_pkg.sv @@
// Package for the task queue: request, result and entry layouts, status codes,
// request codes and configuration register indexes.
// No dependencies.
`default_nettype none

package tqsf_pkg;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAP  = 8'd1;

    localparam logic       MODE_RESET = 1'b0;
    localparam logic [4:0] CAP_RESET  = 5'd16;

    typedef struct packed {
        logic        req_type;
        logic [15:0] conn_tag;
        logic [31:0] file_size;
        logic        static_flag;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_conn_tag;
        logic [31:0] out_file_size;
        logic        out_static_flag;
        logic [4:0]  entry_count;
    } t_out_item;

    typedef struct packed {
        logic        static_flag;
        logic [31:0] file_size;
        logic [15:0] conn_tag;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

@@ sv/tqsf_ram.sv @@
// Entry store: one write port, one read port with registered read data.
// Depends on nothing; width and depth come from the instantiating module.
`default_nettype none

module tqsf_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 49
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ sv/tqsf_min_unit.sv @@
// Running-minimum unit for the smallest-first search: one 32-bit compare,
// keeps the best entry and its slot. Uses tqsf_pkg for the entry layout.
`default_nettype none

module tqsf_min_unit #(
    parameter int unsigned AW = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_load,
    input  wire logic            i_update,
    input  wire tqsf_pkg::t_entry i_entry,
    input  wire logic [AW-1:0]   i_idx,
    output tqsf_pkg::t_entry     o_best,
    output logic      [AW-1:0]   o_best_idx
);

    tqsf_pkg::t_entry r_best;
    logic [AW-1:0]    r_best_idx;
    logic             take;

    // Equal sizes go to the later slot in queue order.
    assign take = i_update && (i_load || (i_entry.file_size <= r_best.file_size));

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best     <= i_entry;
            r_best_idx <= i_idx;
        end
    end

    assign o_best     = r_best;
    assign o_best_idx = r_best_idx;

endmodule

`default_nettype wire

@@ sv/task_queue_fifo_or_smallest_first_core.sv @@
// Bounded task queue with FIFO or smallest-file-size-first pop. One request is
// handled at a time; o_in_ready is high only while the sequencer is idle. A
// push or a rejected or empty request passes through S_EXEC and S_DONE to
// o_out_valid. A pop reads the store through its single registered read
// port: a FIFO pop reads only the head entry in S_SCAN, a smallest-first pop
// reads all N held entries in S_SCAN, then every later entry is shifted down
// to close the gap left by the popped one, by S_SH_RD and S_SH_WR (one read
// and one write per entry on the store). A finished result sits in an output
// register, so the next request can be taken while the result waits. The
// entry store needs no clearing after reset.
`default_nettype none

module task_queue_fifo_or_smallest_first_core #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire tqsf_pkg::t_in_item                     i_in,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output tqsf_pkg::t_out_item                         o_out,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [tqsf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [tqsf_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned EW = (CW > 5) ? CW : 5;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_SH_RD = 6'b001000,
        S_SH_WR = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] a);
        return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_prev(input logic [AW-1:0] a);
        return (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
    endfunction

    t_state              r_state, n_state;
    logic                r_mode;
    logic [4:0]          r_cap;
    logic [AW-1:0]       r_head, n_head;
    logic [AW-1:0]       r_tail, n_tail;
    logic [CW-1:0]       r_count, n_count;
    tqsf_pkg::t_in_item  r_req, n_req;
    logic [AW-1:0]       r_idx, n_idx;
    logic [AW-1:0]       r_wi, n_wi;
    logic [CW-1:0]       r_left, n_left;
    logic                r_dv, n_dv;
    logic [AW-1:0]       r_didx, n_didx;
    tqsf_pkg::t_out_item r_res, n_res;
    logic                r_out_valid;
    tqsf_pkg::t_out_item r_out;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    tqsf_pkg::t_entry    ram_wdata, ram_rdata;
    logic                mu_load, mu_update;
    tqsf_pkg::t_entry    mu_best;
    logic [AW-1:0]       mu_idx;

    logic [EW-1:0]       cap_w, eff_cap;
    logic                full;
    logic                slot_free;
    tqsf_pkg::t_out_item pop_res;
    tqsf_pkg::t_entry    push_entry;
    logic [CW:0]         head_plus_count, exp_tail;

    tqsf_ram #(
        .DEPTH (DEPTH),
        .WIDTH (tqsf_pkg::ENTRY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    tqsf_min_unit #(
        .AW (AW)
    ) u_min (
        .i_clk      (i_clk),
        .i_load     (mu_load),
        .i_update   (mu_update),
        .i_entry    (ram_rdata),
        .i_idx      (r_didx),
        .o_best     (mu_best),
        .o_best_idx (mu_idx)
    );

    // Capacity 0 acts as 1, anything above the built depth as the depth.
    always_comb begin
        cap_w = EW'(r_cap);
        if (cap_w == '0) begin
            eff_cap = EW'(1);
        end else if (cap_w > EW'(DEPTH)) begin
            eff_cap = EW'(DEPTH);
        end else begin
            eff_cap = cap_w;
        end
        full = EW'(r_count) >= eff_cap;
    end

    assign push_entry.static_flag = r_req.static_flag;
    assign push_entry.file_size   = r_req.file_size;
    assign push_entry.conn_tag    = r_req.conn_tag;

    always_comb begin
        pop_res.status          = tqsf_pkg::ST_DONE;
        pop_res.out_conn_tag    = mu_best.conn_tag;
        pop_res.out_file_size   = mu_best.file_size;
        pop_res.out_static_flag = mu_best.static_flag;
        pop_res.entry_count     = 5'(r_count - CW'(1));
    end

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_req     = r_req;
        n_idx     = r_idx;
        n_wi      = r_wi;
        n_left    = r_left;
        n_dv      = r_dv;
        n_didx    = r_didx;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_tail;
        ram_raddr = r_idx;
        ram_wdata = push_entry;
        mu_load   = 1'b0;
        mu_update = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res       = '0;
                n_res.entry_count = 5'(r_count);
                n_dv        = 1'b0;
                if (r_req.req_type == tqsf_pkg::REQ_PUSH) begin
                    if (full) begin
                        n_res.status = tqsf_pkg::ST_FULL;
                    end else begin
                        ram_we            = 1'b1;
                        n_tail            = f_next(r_tail);
                        n_count           = r_count + CW'(1);
                        n_res.entry_count = 5'(r_count + CW'(1));
                    end
                    n_state = S_DONE;
                end else if (r_count == '0) begin
                    n_res.status = tqsf_pkg::ST_EMPTY;
                    n_state      = S_DONE;
                end else begin
                    n_idx   = r_head;
                    n_left  = r_mode ? r_count : CW'(1);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_dv = 1'b0;
                if (r_left != '0) begin
                    ram_re = 1'b1;
                    n_didx = r_idx;
                    n_idx  = f_next(r_idx);
                    n_left = r_left - CW'(1);
                    n_dv   = 1'b1;
                end
                // The first entry read is always the head slot.
                if (r_dv) begin
                    mu_update = 1'b1;
                    mu_load   = (r_didx == r_head);
                end
                if (r_left == '0 && !r_dv) begin
                    if (mu_idx == r_head) begin
                        n_head  = f_next(r_head);
                        n_count = r_count - CW'(1);
                        n_res   = pop_res;
                        n_state = S_DONE;
                    end else if (f_next(mu_idx) == r_tail) begin
                        n_tail  = f_prev(r_tail);
                        n_count = r_count - CW'(1);
                        n_res   = pop_res;
                        n_state = S_DONE;
                    end else begin
                        n_wi    = mu_idx;
                        n_idx   = f_next(mu_idx);
                        n_state = S_SH_RD;
                    end
                end
            end
            S_SH_RD: begin
                ram_re  = 1'b1;
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                // Shift one entry down over the gap.
                ram_we    = 1'b1;
                ram_waddr = r_wi;
                ram_wdata = ram_rdata;
                n_wi      = r_idx;
                n_idx     = f_next(r_idx);
                if (f_next(r_idx) == r_tail) begin
                    n_tail  = f_prev(r_tail);
                    n_count = r_count - CW'(1);
                    n_res   = pop_res;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SH_RD;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_dv        <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_dv    <= n_dv;
            r_left  <= n_left;
            if (r_state == S_DONE && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_idx  <= n_idx;
        r_wi   <= n_wi;
        r_didx <= n_didx;
        r_res  <= n_res;
        if (r_state == S_DONE && slot_free) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= tqsf_pkg::MODE_RESET;
            r_cap  <= tqsf_pkg::CAP_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == tqsf_pkg::CFG_IDX_MODE) begin
                r_mode <= i_cfg_data[0];
            end else if (i_cfg_index == tqsf_pkg::CFG_IDX_CAP) begin
                r_cap <= i_cfg_data[4:0];
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    // Expected tail slot from head and count, for the ring check below.
    always_comb begin
        head_plus_count = (CW + 1)'(r_head) + (CW + 1)'(r_count);
        exp_tail = (head_plus_count >= (CW + 1)'(DEPTH))
                 ? head_plus_count - (CW + 1)'(DEPTH) : head_plus_count;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("held count above depth");

    a_ring_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (AW'(exp_tail) == r_tail))
        else $error("head, tail and count disagree");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second transaction taken while busy");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_count != '0))
        else $error("pop search on an empty queue");

endmodule

`default_nettype wire
